// ===== hdl/key_value_line_tokenizer_top_defines.svh =====
// Assertion macros for the key/value line tokenizer.
// Used by the top level only; needs clock and reset in scope.
`ifndef KEY_VALUE_LINE_TOKENIZER_TOP_DEFINES_SVH
`define KEY_VALUE_LINE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KVLT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KVLT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/kvlt_pkg.sv =====
// Shared types, constants and byte classifiers for the key/value line tokenizer.
// No dependencies.
package kvlt_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int FIELD_BITS  = 16;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 88;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [FIELD_BITS-1:0]  field_type;

   localparam offset_type POS_MAX   = {OFFSET_BITS{1'b1}};
   localparam field_type  COUNT_MAX = {FIELD_BITS{1'b1}};

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;

   localparam logic KIND_PAIR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // One queue entry: an optional pair followed by an optional summary.
   typedef struct packed {
      logic       has_pair;
      logic       has_sum;
      offset_type key_start;
      offset_type key_end;
      offset_type value_start;
      offset_type value_end;
      field_type  pair_count;
      logic       empty_res;
      logic       too_long;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Whitespace (TAB through CR, space), ':' or '='.
   function automatic logic is_sep(input logic [7:0] c);
      is_sep = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) ||
               (c == CH_COLON) || (c == CH_EQUAL);
   endfunction

   function automatic logic is_eol(input logic [7:0] c);
      is_eol = (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

// ===== hdl/key_value_line_tokenizer_top.sv =====
// Key/value line tokenizer: scanner, result queue and output stage.
// Depends on kvlt_pkg, kvlt_front, kvlt_queue, kvlt_back and the defines header.
//
// Usage:
//   Input channel (req_*): one text byte per item in req_tdata[7:0];
//   req_tlast high marks end of text (no byte carried). A zero byte also
//   ends the text. Bytes are taken one per cycle while the queue is not full.
//   Result channel (rsp_*): rsp_tuser is the kind (0 pair, 1 summary);
//   rsp_tlast marks the last result caused by one input item. Each pair
//   is reported when its value ends (at '#', CR, LF or end of text); end
//   of text yields an optional closing pair and then the summary.
//   Each result is written into the queue and then loaded into the
//   output register, from which it leaves.
//   Throughput: one byte per cycle while the queue is not full; an
//   end-of-text item with an open value fills the output register twice,
//   first with the pair and then with the summary.
//   Stall: when the receiver holds rsp_tready low, results collect in a
//   four-entry queue; req_tready drops only when that queue is full.
//   Reset: synchronous, active high; clears the scan state, offsets,
//   pair count, queue and output valid flag. No clearing pass is needed.
`include "key_value_line_tokenizer_top_defines.svh"

module key_value_line_tokenizer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata: [7:0] ch
   input  logic [kvlt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // req_tlast: end_of_text
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata: [15:0] key_start, [31:16] key_end, [47:32] value_start,
   //            [63:48] value_end, [79:64] pair_count, [80] empty_res,
   //            [81] too_long, [87:82] zero
   output logic [kvlt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // rsp_tuser: kind
   output logic                                 rsp_tuser,
   // rsp_tlast: final_res
   output logic                                 rsp_tlast
);

   logic                      push;
   logic                      pop;
   kvlt_pkg::entry_type       push_entry;
   kvlt_pkg::entry_type       head;
   kvlt_pkg::fifo_status_type fifo_status;

   // Classify bytes and update the scan state; queue any results.
   kvlt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Decouple the scanner from output stalls.
   kvlt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   // Expand entries into pair and summary items.
   kvlt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // A summary carries zero offsets and always closes its input's results.
   `KVLT_ASSERT_SAME(a_summary_shape, rsp_tvalid && rsp_tuser == kvlt_pkg::KIND_SUMMARY, rsp_tlast && rsp_tdata[63:0] == 64'b0, "summary with offsets or without last")
   // A pair never claims an empty text.
   `KVLT_ASSERT_SAME(a_pair_not_empty, rsp_tvalid && rsp_tuser == kvlt_pkg::KIND_PAIR, !rsp_tdata[80], "pair result with empty flag")
   // Never write into a full queue.
   `KVLT_ASSERT_SAME(a_no_overflow, push, !fifo_status.full, "push into full queue")
   // End of text always leaves a summary entry behind.
   `KVLT_ASSERT_NEXT(a_eot_queued, req_tvalid && req_tready && req_tlast, !fifo_status.empty, "end of text not queued")

endmodule

// ===== hdl/kvlt_front.sv =====
// Front part: accepts text bytes, runs the line scanner, queues results.
// Depends on kvlt_pkg.
module kvlt_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [kvlt_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic                                   req_tlast,
   input  kvlt_pkg::fifo_status_type              fifo_status,
   output logic                                   push,
   output kvlt_pkg::entry_type                    push_entry
);

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_COMMENT = 5'b00010,
      MODE_KEY     = 5'b00100,
      MODE_SEP     = 5'b01000,
      MODE_VALUE   = 5'b10000
   } mode_type;

   mode_type             mode_ff, mode_in;
   kvlt_pkg::offset_type pos_ff, pos_in;
   kvlt_pkg::offset_type ks_ff, ks_in;
   kvlt_pkg::offset_type ke_ff, ke_in;
   kvlt_pkg::offset_type vs_ff, vs_in;
   kvlt_pkg::offset_type ts_ff, ts_in;
   logic                 tseen_ff, tseen_in;
   kvlt_pkg::field_type  pairs_ff, pairs_in;
   logic                 ovf_ff, ovf_in;

   logic                 accept;
   logic                 eot;
   logic                 at_max;
   logic                 ovf_cur;
   logic [7:0]           ch;
   kvlt_pkg::field_type  pairs_inc;

   assign req_tready = !fifo_status.full;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata[7:0];
   assign eot        = req_tlast || (ch == kvlt_pkg::CH_NUL);
   assign at_max     = (pos_ff == kvlt_pkg::POS_MAX);
   assign ovf_cur    = ovf_ff || at_max;
   assign pairs_inc  = (pairs_ff == kvlt_pkg::COUNT_MAX) ? pairs_ff
                                                          : pairs_ff + 1'b1;

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      ks_in      = ks_ff;
      ke_in      = ke_ff;
      vs_in      = vs_ff;
      ts_in      = ts_ff;
      tseen_in   = tseen_ff;
      pairs_in   = pairs_ff;
      ovf_in     = ovf_ff;
      push       = 1'b0;
      push_entry = '0;
      push_entry.key_start   = ks_ff;
      push_entry.key_end     = ke_ff;
      push_entry.value_start = vs_ff;
      if (accept) begin
         if (eot) begin
            // close an open value, then summarize and start a new text
            push = 1'b1;
            push_entry.has_sum  = 1'b1;
            push_entry.too_long = ovf_ff;
            if (mode_ff == MODE_VALUE) begin
               push_entry.has_pair   = 1'b1;
               push_entry.value_end  = tseen_ff ? ts_ff : pos_ff;
               push_entry.pair_count = pairs_inc;
            end else begin
               push_entry.pair_count = pairs_ff;
            end
            push_entry.empty_res = (push_entry.pair_count == '0);
            mode_in  = MODE_IDLE;
            pos_in   = '0;
            ks_in    = '0;
            ke_in    = '0;
            vs_in    = '0;
            ts_in    = '0;
            tseen_in = 1'b0;
            pairs_in = '0;
            ovf_in   = 1'b0;
         end else begin
            // the byte offset is pos_ff; hold it at the maximum
            pos_in = at_max ? pos_ff : pos_ff + 1'b1;
            ovf_in = ovf_cur;
            unique case (mode_ff)
               MODE_COMMENT: begin
                  if (kvlt_pkg::is_eol(ch)) mode_in = MODE_IDLE;
               end
               MODE_KEY: begin
                  if (ch == kvlt_pkg::CH_HASH) begin
                     mode_in = MODE_COMMENT;
                  end else if (kvlt_pkg::is_eol(ch)) begin
                     mode_in = MODE_IDLE;
                  end else if (kvlt_pkg::is_sep(ch)) begin
                     ke_in   = pos_ff;
                     mode_in = MODE_SEP;
                  end
               end
               MODE_SEP: begin
                  if (kvlt_pkg::is_eol(ch)) begin
                     mode_in = MODE_IDLE;
                  end else if (ch == kvlt_pkg::CH_HASH) begin
                     mode_in = MODE_COMMENT;
                  end else if (!kvlt_pkg::is_sep(ch)) begin
                     vs_in    = pos_ff;
                     tseen_in = 1'b0;
                     ts_in    = '0;
                     mode_in  = MODE_VALUE;
                  end
               end
               MODE_VALUE: begin
                  if (ch == kvlt_pkg::CH_HASH || kvlt_pkg::is_eol(ch)) begin
                     push = 1'b1;
                     push_entry.has_pair   = 1'b1;
                     push_entry.value_end  = tseen_ff ? ts_ff : pos_ff;
                     push_entry.pair_count = pairs_inc;
                     push_entry.too_long   = ovf_cur;
                     pairs_in = pairs_inc;
                     mode_in  = (ch == kvlt_pkg::CH_HASH) ? MODE_COMMENT : MODE_IDLE;
                  end else if (tseen_ff) begin
                     if (!kvlt_pkg::is_sep(ch)) tseen_in = 1'b0;
                  end else if (kvlt_pkg::is_sep(ch)) begin
                     ts_in    = pos_ff;
                     tseen_in = 1'b1;
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
                  if (ch == kvlt_pkg::CH_HASH || ch == kvlt_pkg::CH_LBRACK) begin
                     mode_in = MODE_COMMENT;
                  end else if (!kvlt_pkg::is_sep(ch)) begin
                     ks_in   = pos_ff;
                     mode_in = MODE_KEY;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         ks_ff    <= '0;
         ke_ff    <= '0;
         vs_ff    <= '0;
         ts_ff    <= '0;
         tseen_ff <= 1'b0;
         pairs_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         ks_ff    <= ks_in;
         ke_ff    <= ke_in;
         vs_ff    <= vs_in;
         ts_ff    <= ts_in;
         tseen_ff <= tseen_in;
         pairs_ff <= pairs_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== hdl/kvlt_queue.sv =====
// Short result queue between the scanner and the output stage.
// Depends on kvlt_pkg.
module kvlt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kvlt_pkg::entry_type       push_entry,
   input  logic                      pop,
   output kvlt_pkg::entry_type       head,
   output kvlt_pkg::fifo_status_type status
);

   kvlt_pkg::entry_type        mem_ff [kvlt_pkg::FIFO_DEPTH];
   logic [kvlt_pkg::FIFO_AW-1:0] wr_ff, wr_in;
   logic [kvlt_pkg::FIFO_AW-1:0] rd_ff, rd_in;
   logic [kvlt_pkg::FIFO_AW:0]   count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign status.full  = (count_ff == (kvlt_pkg::FIFO_AW+1)'(kvlt_pkg::FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/kvlt_back.sv =====
// Back part: expands queue entries into result items in an output register.
// Depends on kvlt_pkg.
module kvlt_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kvlt_pkg::entry_type                  head,
   input  kvlt_pkg::fifo_status_type            fifo_status,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [kvlt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   logic                               valid_ff, valid_in;
   logic [kvlt_pkg::RSP_DATA_BITS-1:0] data_ff, data_in;
   logic                               user_ff, user_in;
   logic                               last_ff, last_in;
   logic                               pair_done_ff, pair_done_in;
   logic                               load;
   logic                               send_pair;

   assign load      = (!valid_ff || rsp_tready) && !fifo_status.empty;
   assign send_pair = head.has_pair && !pair_done_ff;

   always_comb begin
      data_in      = data_ff;
      user_in      = user_ff;
      last_in      = last_ff;
      pair_done_in = pair_done_ff;
      pop          = 1'b0;
      valid_in     = rsp_tready ? 1'b0 : valid_ff;
      if (load) begin
         valid_in = 1'b1;
         if (send_pair) begin
            user_in = kvlt_pkg::KIND_PAIR;
            last_in = !head.has_sum;
            data_in = {6'b0, head.too_long, 1'b0, head.pair_count,
                       16'(head.value_end), 16'(head.value_start),
                       16'(head.key_end), 16'(head.key_start)};
            // keep the entry when a summary still follows
            pop          = !head.has_sum;
            pair_done_in = head.has_sum;
         end else begin
            user_in = kvlt_pkg::KIND_SUMMARY;
            last_in = 1'b1;
            data_in = {6'b0, head.too_long, head.empty_res, head.pair_count, 64'b0};
            pop          = 1'b1;
            pair_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         pair_done_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         pair_done_ff <= pair_done_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for key_value_line_tokenizer_top: drives text bytes, predicts
// every pair and end-of-text summary, and checks the result stream item by item.
// Depends on kvlt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;

   // Byte codes that the package does not name.
   localparam logic [7:0] CH_VTAB  = 8'h0B;
   localparam logic [7:0] CH_FFEED = 8'h0C;

   localparam int IDLE_LIMIT  = 5000;  // cycles with no handshake on either side
   localparam int PRINT_LIMIT = 40;    // mismatch lines shown before going quiet
   localparam int DRAIN_WAIT  = 20;    // output register latency plus margin
   localparam int RANDOM_PER_PHASE = 165;

   typedef enum logic [4:0] {
      SCAN_IDLE    = 5'b00001,
      SCAN_COMMENT = 5'b00010,
      SCAN_KEY     = 5'b00100,
      SCAN_SEP     = 5'b01000,
      SCAN_VALUE   = 5'b10000
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
   } text_item_type;

   typedef struct packed {
      logic                kind;
      kvlt_pkg::field_type key_start;
      kvlt_pkg::field_type key_end;
      kvlt_pkg::field_type value_start;
      kvlt_pkg::field_type value_end;
      kvlt_pkg::field_type pair_count;
      logic                empty_res;
      logic                too_long;
      logic                final_res;
   } token_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [kvlt_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                               req_tlast  = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [kvlt_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tuser;
   logic                               rsp_tlast;

   key_value_line_tokenizer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_item_type    pending_bytes[$];
   token_result_type expected_results[$];
   text_item_type    next_byte;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;
   int stimulus_items = 0;

   // Predictor state: mirrors the scanner one accepted item at a time.
   scan_mode_type        line_mode        = SCAN_IDLE;
   kvlt_pkg::offset_type text_offset      = '0;
   kvlt_pkg::offset_type key_first        = '0;
   kvlt_pkg::offset_type key_stop         = '0;
   kvlt_pkg::offset_type value_first      = '0;
   kvlt_pkg::offset_type blank_run_start  = '0;
   logic                 blank_run_open   = 1'b0;
   kvlt_pkg::field_type  pairs_seen       = '0;
   logic                 offset_saturated = 1'b0;

   // Whitespace, ':' and '=' all split a key from its value.
   function automatic logic splits_fields(input logic [7:0] c);
      case (c)
         kvlt_pkg::CH_SPACE, kvlt_pkg::CH_TAB, kvlt_pkg::CH_LF, CH_VTAB, CH_FFEED,
         kvlt_pkg::CH_CR, kvlt_pkg::CH_COLON, kvlt_pkg::CH_EQUAL:
            splits_fields = 1'b1;
         default:
            splits_fields = 1'b0;
      endcase
   endfunction

   task automatic close_pair(input kvlt_pkg::offset_type value_stop, input logic last);
      token_result_type r;
      if (pairs_seen != kvlt_pkg::COUNT_MAX) pairs_seen = pairs_seen + 1'b1;
      r = '0;
      r.kind        = kvlt_pkg::KIND_PAIR;
      r.key_start   = key_first;
      r.key_end     = key_stop;
      r.value_start = value_first;
      r.value_end   = value_stop;
      r.pair_count  = pairs_seen;
      r.too_long    = offset_saturated;
      r.final_res   = last;
      expected_results.push_back(r);
   endtask

   task automatic scan_text_byte(input logic [7:0] ch, input logic text_end);
      kvlt_pkg::offset_type at;
      logic                 line_break;
      token_result_type     r;
      line_break = (ch == kvlt_pkg::CH_CR) || (ch == kvlt_pkg::CH_LF);
      if (text_end || ch == kvlt_pkg::CH_NUL) begin
         // Close an open value first, then summarize and start a fresh text.
         if (line_mode == SCAN_VALUE)
            close_pair(blank_run_open ? blank_run_start : text_offset, 1'b0);
         r = '0;
         r.kind       = kvlt_pkg::KIND_SUMMARY;
         r.pair_count = pairs_seen;
         r.empty_res  = (pairs_seen == '0);
         r.too_long   = offset_saturated;
         r.final_res  = 1'b1;
         expected_results.push_back(r);
         line_mode        = SCAN_IDLE;
         text_offset      = '0;
         key_first        = '0;
         key_stop         = '0;
         value_first      = '0;
         blank_run_start  = '0;
         blank_run_open   = 1'b0;
         pairs_seen       = '0;
         offset_saturated = 1'b0;
      end else begin
         // Hold the offset at its maximum once the range is used up.
         if (text_offset >= kvlt_pkg::POS_MAX) begin
            at = kvlt_pkg::POS_MAX;
            offset_saturated = 1'b1;
         end else begin
            at = text_offset;
            text_offset = text_offset + 1'b1;
         end
         case (line_mode)
            SCAN_COMMENT: begin
               if (line_break) line_mode = SCAN_IDLE;
            end
            SCAN_KEY: begin
               if (ch == kvlt_pkg::CH_HASH) begin
                  line_mode = SCAN_COMMENT;
               end else if (line_break) begin
                  line_mode = SCAN_IDLE;
               end else if (splits_fields(ch)) begin
                  key_stop  = at;
                  line_mode = SCAN_SEP;
               end
            end
            SCAN_SEP: begin
               if (line_break) begin
                  line_mode = SCAN_IDLE;
               end else if (ch == kvlt_pkg::CH_HASH) begin
                  line_mode = SCAN_COMMENT;
               end else if (!splits_fields(ch)) begin
                  value_first     = at;
                  blank_run_open  = 1'b0;
                  blank_run_start = '0;
                  line_mode       = SCAN_VALUE;
               end
            end
            SCAN_VALUE: begin
               if (ch == kvlt_pkg::CH_HASH || line_break) begin
                  close_pair(blank_run_open ? blank_run_start : at, 1'b1);
                  line_mode = (ch == kvlt_pkg::CH_HASH) ? SCAN_COMMENT : SCAN_IDLE;
               end else if (blank_run_open) begin
                  if (!splits_fields(ch)) blank_run_open = 1'b0;
               end else if (splits_fields(ch)) begin
                  blank_run_start = at;
                  blank_run_open  = 1'b1;
               end
            end
            default: begin
               if (ch == kvlt_pkg::CH_HASH || ch == kvlt_pkg::CH_LBRACK) begin
                  line_mode = SCAN_COMMENT;
               end else if (!splits_fields(ch)) begin
                  key_first = at;
                  line_mode = SCAN_KEY;
               end else begin
                  line_mode = SCAN_IDLE;
               end
            end
         endcase
      end
   endtask

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_token();
      token_result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: result expected none, got tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
      end else begin
         want = expected_results.pop_front();
         report_field("kind",        want.kind,        rsp_tuser);
         report_field("key_start",   want.key_start,   rsp_tdata[15:0]);
         report_field("key_end",     want.key_end,     rsp_tdata[31:16]);
         report_field("value_start", want.value_start, rsp_tdata[47:32]);
         report_field("value_end",   want.value_end,   rsp_tdata[63:48]);
         report_field("pair_count",  want.pair_count,  rsp_tdata[79:64]);
         report_field("empty_res",   want.empty_res,   rsp_tdata[80]);
         report_field("too_long",    want.too_long,    rsp_tdata[81]);
         report_field("final_res",   want.final_res,   rsp_tlast);
      end
   endtask

   // Driver: advance to the next pending item only once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_byte = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_byte.ch;
            req_tlast  <= next_byte.eot;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on every accepted byte, then check any accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) scan_text_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_token();
      end
   end

   // Watchdog: end the run when neither side moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_item(input logic [7:0] ch, input logic eot);
      text_item_type item;
      item.ch  = ch;
      item.eot = eot;
      pending_bytes.push_back(item);
      stimulus_items++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
   endtask

   // End a text either by tlast with a random byte or by a zero byte.
   task automatic add_end_of_text();
      if ($urandom_range(0, 3) == 0) add_item(kvlt_pkg::CH_NUL, 1'b0);
      else add_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] pick_sep();
      case ($urandom_range(0, 5))
         0: pick_sep = kvlt_pkg::CH_SPACE;
         1: pick_sep = kvlt_pkg::CH_TAB;
         2: pick_sep = kvlt_pkg::CH_COLON;
         3: pick_sep = kvlt_pkg::CH_EQUAL;
         4: pick_sep = CH_VTAB;
         default: pick_sep = CH_FFEED;
      endcase
   endfunction

   // Word bytes: anything that neither splits fields nor starts a comment.
   task automatic add_word(input int len, input logic line_start);
      logic [7:0] c;
      for (int i = 0; i < len; i++) begin
         do c = 8'($urandom_range(1, 255));
         while (splits_fields(c) || c == kvlt_pkg::CH_HASH ||
                (line_start && i == 0 && c == kvlt_pkg::CH_LBRACK));
         add_item(c, 1'b0);
      end
   endtask

   task automatic add_line_end();
      case ($urandom_range(0, 4))
         0: add_item(kvlt_pkg::CH_LF, 1'b0);
         1: add_item(kvlt_pkg::CH_CR, 1'b0);
         2: begin
            add_item(kvlt_pkg::CH_CR, 1'b0);
            add_item(kvlt_pkg::CH_LF, 1'b0);
         end
         3: begin
            add_item(kvlt_pkg::CH_HASH, 1'b0);
            add_word($urandom_range(0, 4), 1'b0);
            add_item(kvlt_pkg::CH_LF, 1'b0);
         end
         default: add_end_of_text();
      endcase
   endtask

   // Mostly well-formed lines with random content, the rest broken lines and noise.
   task automatic add_random_line();
      int shape;
      shape = $urandom_range(0, 99);
      if (shape < 60) begin
         repeat ($urandom_range(0, 2))
            add_item($urandom_range(0, 1) ? kvlt_pkg::CH_SPACE : kvlt_pkg::CH_TAB, 1'b0);
         add_word($urandom_range(1, 6), 1'b1);
         repeat ($urandom_range(1, 3)) add_item(pick_sep(), 1'b0);
         add_word($urandom_range(1, 4), 1'b0);
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) add_item(pick_sep(), 1'b0);
            add_word($urandom_range(1, 4), 1'b0);
         end
         repeat ($urandom_range(0, 2)) add_item(pick_sep(), 1'b0);
         add_line_end();
      end else if (shape < 70) begin
         add_item($urandom_range(0, 1) ? kvlt_pkg::CH_HASH : kvlt_pkg::CH_LBRACK, 1'b0);
         add_word($urandom_range(0, 5), 1'b0);
         add_item(kvlt_pkg::CH_LF, 1'b0);
      end else if (shape < 85) begin
         add_word($urandom_range(1, 4), 1'b1);
         case ($urandom_range(0, 2))
            0: add_item($urandom_range(0, 1) ? kvlt_pkg::CH_LF : kvlt_pkg::CH_CR, 1'b0);
            1: begin
               repeat ($urandom_range(1, 3)) add_item(pick_sep(), 1'b0);
               add_item($urandom_range(0, 1) ? kvlt_pkg::CH_LF : kvlt_pkg::CH_CR, 1'b0);
            end
            default: begin
               repeat ($urandom_range(0, 2)) add_item(pick_sep(), 1'b0);
               add_item(kvlt_pkg::CH_HASH, 1'b0);
               add_word($urandom_range(0, 3), 1'b0);
               add_item(kvlt_pkg::CH_LF, 1'b0);
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) add_item(8'($urandom_range(1, 255)), 1'b0);
      end
      if ($urandom_range(0, 99) < 8) add_end_of_text();
   endtask

   // Hold until every item is taken and every predicted result has arrived.
   task automatic wait_for_drain();
      while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct);
      int first;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      first = stimulus_items;
      while (stimulus_items - first < RANDOM_PER_PHASE) add_random_line();
      wait_for_drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty text: summary alone with the empty flag; the byte is ignored under tlast.
      add_item(8'hFF, 1'b1);
      // Colon separator, trailing blank trimmed, pair closed by carriage return.
      add_text("a");
      add_item(kvlt_pkg::CH_COLON, 1'b0);
      add_text("b");
      add_item(kvlt_pkg::CH_SPACE, 1'b0);
      add_item(kvlt_pkg::CH_CR, 1'b0);
      // Bracket at line start drops the line.
      add_item(kvlt_pkg::CH_LBRACK, 1'b0);
      add_text("x");
      add_item(kvlt_pkg::CH_LF, 1'b0);
      // Newline while skipping the separator drops the key.
      add_text("k");
      add_item(kvlt_pkg::CH_SPACE, 1'b0);
      add_item(kvlt_pkg::CH_CR, 1'b0);
      // Hash inside the key, then inside the separator.
      add_text("k");
      add_item(kvlt_pkg::CH_HASH, 1'b0);
      add_item(kvlt_pkg::CH_LF, 1'b0);
      add_text("k");
      add_item(kvlt_pkg::CH_TAB, 1'b0);
      add_item(kvlt_pkg::CH_HASH, 1'b0);
      add_item(kvlt_pkg::CH_LF, 1'b0);
      // Value closed by a hash; comment runs to the carriage return.
      add_text("x");
      add_item(kvlt_pkg::CH_EQUAL, 1'b0);
      add_item(8'hFF, 1'b0);
      add_text("y");
      add_item(kvlt_pkg::CH_HASH, 1'b0);
      add_item(kvlt_pkg::CH_CR, 1'b0);
      // Open value closed by a zero byte: pair, then summary.
      add_text("q");
      add_item(kvlt_pkg::CH_SPACE, 1'b0);
      add_text("v");
      add_item(kvlt_pkg::CH_SPACE, 1'b0);
      add_item(kvlt_pkg::CH_NUL, 1'b0);
      wait_for_drain();

      run_random_phase(0, 0);
      run_random_phase(47, 0);
      run_random_phase(0, 47);
      run_random_phase(30, 30);

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/kvlt_pkg.sv
hdl/kvlt_front.sv
hdl/kvlt_queue.sv
hdl/kvlt_back.sv
hdl/key_value_line_tokenizer_top.sv
test/testbench.sv
